@@ rtl/core/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// Sector connectivity test package
// Field widths, bearing table, reason codes and beat types shared by the
// sector connectivity test.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int ANGLE_WIDTH  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int GUARD_BITS   = 8;
   localparam int ATAN_LEN     = 24;

   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // atan(2^-i) / (2*pi) in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [1:0] {
      REASON_CONNECTED      = 2'd0,
      REASON_SAME_POINT     = 2'd1,
      REASON_BEYOND_REACH   = 2'd2,
      REASON_OUTSIDE_SECTOR = 2'd3
   } reason_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] src_x;
      logic signed [COORD_WIDTH-1:0] src_y;
      logic signed [COORD_WIDTH-1:0] dst_x;
      logic signed [COORD_WIDTH-1:0] dst_y;
      logic        [COORD_WIDTH:0]   reach;
      logic        [ANGLE_WIDTH-1:0] start_angle;
      logic        [ANGLE_WIDTH-1:0] sector_width;
   } req_type;

   typedef struct packed {
      logic       connected;
      logic [1:0] reason;
   } rsp_type;

endpackage

@@ rtl/core/cct_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One registered micro-rotation that drives the y component toward zero and
// accumulates the bearing in units of 2^-32 turn.
// ----------------------------------------------------------------------------
module cct_cordic_stage #(
   parameter int XY_WIDTH = 28,
   parameter int STEP     = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic signed [XY_WIDTH-1:0] in_x,
   input  logic signed [XY_WIDTH-1:0] in_y,
   input  logic        [31:0]         in_acc,
   output logic                       out_valid,
   output logic signed [XY_WIDTH-1:0] out_x,
   output logic signed [XY_WIDTH-1:0] out_y,
   output logic        [31:0]         out_acc
);

   logic                       valid_ff;
   logic signed [XY_WIDTH-1:0] x_ff, x_in, y_ff, y_in;
   logic        [31:0]         acc_ff, acc_in;
   logic signed [XY_WIDTH-1:0] x_shift, y_shift;

   assign x_shift = in_x >>> STEP;
   assign y_shift = in_y >>> STEP;

   always_comb begin
      if (!in_y[XY_WIDTH-1]) begin
         x_in   = in_x + y_shift;
         y_in   = in_y - x_shift;
         acc_in = in_acc + cct_pkg::ATAN_TURNS[STEP];
      end else begin
         x_in   = in_x - y_shift;
         y_in   = in_y + x_shift;
         acc_in = in_acc - cct_pkg::ATAN_TURNS[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_acc   = acc_ff;

endmodule

@@ rtl/core/cone_connectivity_test.sv @@
// ----------------------------------------------------------------------------
// Sector connectivity test
// Decides whether a target point lies within reach of a source point and
// inside the circular sector given by a start angle and a width.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request beat passes two setup stages, one stage per
// CORDIC rotation and one sector compare stage before its response beat.
// Throughput: one beat per cycle; a stalled response freezes the pipeline.
// Reset clears all valid bits; the pipeline is empty after reset.
module cone_connectivity_test #(
   parameter int CORDIC_STEPS = cct_pkg::CORDIC_STEPS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cct_pkg::rsp_type rsp_data
);

   localparam int CW       = cct_pkg::COORD_WIDTH;
   localparam int AW       = cct_pkg::ANGLE_WIDTH;
   localparam int DW       = CW + 1;
   localparam int XY_WIDTH = DW + cct_pkg::GUARD_BITS + 3;
   localparam int SQ_WIDTH = 2 * DW;
   localparam int SUM_W    = SQ_WIDTH + 1;
   localparam logic [31:0] ROUND_HALF = 32'(1) << (31 - AW);

   logic advance;

   // Setup stage one: differences and same-point flag.
   logic                 p1_valid_ff;
   logic signed [DW-1:0] p1_dx_ff, p1_dx_in, p1_dy_ff, p1_dy_in;
   logic                 p1_same_ff, p1_same_in;
   logic        [DW-1:0] p1_reach_ff;
   logic        [AW-1:0] p1_start_ff, p1_width_ff;

   // Setup stage two: squares and CORDIC start vector.
   logic                       p2_valid_ff;
   logic signed [SQ_WIDTH-1:0] p2_sqx_ff, p2_sqy_ff;
   logic        [SQ_WIDTH-1:0] p2_rr_ff;
   logic                       p2_same_ff;
   logic        [AW-1:0]       p2_start_ff, p2_width_ff;
   logic signed [XY_WIDTH-1:0] p2_x_ff, p2_x_in, p2_y_ff, p2_y_in;
   logic        [31:0]         p2_acc_ff, p2_acc_in;
   logic signed [XY_WIDTH-1:0] x_scaled, y_scaled;

   // CORDIC chain and side line.
   logic                       cordic_valid [CORDIC_STEPS+1];
   logic signed [XY_WIDTH-1:0] cordic_x     [CORDIC_STEPS+1];
   logic signed [XY_WIDTH-1:0] cordic_y     [CORDIC_STEPS+1];
   logic        [31:0]         cordic_acc   [CORDIC_STEPS+1];
   logic                       side_same_ff  [CORDIC_STEPS];
   logic                       side_far_ff   [CORDIC_STEPS];
   logic        [AW-1:0]       side_start_ff [CORDIC_STEPS];
   logic        [AW-1:0]       side_width_ff [CORDIC_STEPS];
   logic        [SUM_W-1:0]    dist_sum;
   logic                       far_in;

   // Output stage.
   logic                rsp_valid_ff;
   cct_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic [31:0]         acc_rounded;
   logic [AW-1:0]       bearing, rel;
   cct_pkg::reason_type reason;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign p1_dx_in   = DW'(req_data.src_x) - DW'(req_data.dst_x);
   assign p1_dy_in   = DW'(req_data.src_y) - DW'(req_data.dst_y);
   assign p1_same_in = (req_data.src_x == req_data.dst_x) &&
                       (req_data.src_y == req_data.dst_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff  <= req_valid;
         p2_valid_ff  <= p1_valid_ff;
         rsp_valid_ff <= cordic_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_dx_ff    <= p1_dx_in;
         p1_dy_ff    <= p1_dy_in;
         p1_same_ff  <= p1_same_in;
         p1_reach_ff <= req_data.reach;
         p1_start_ff <= req_data.start_angle;
         p1_width_ff <= req_data.sector_width;
      end
   end

   assign x_scaled = XY_WIDTH'(p1_dy_ff) <<< cct_pkg::GUARD_BITS;
   assign y_scaled = XY_WIDTH'(p1_dx_ff) <<< cct_pkg::GUARD_BITS;

   always_comb begin
      if (p1_dy_ff[DW-1]) begin
         p2_x_in   = -x_scaled;
         p2_y_in   = -y_scaled;
         p2_acc_in = cct_pkg::HALF_TURN;
      end else begin
         p2_x_in   = x_scaled;
         p2_y_in   = y_scaled;
         p2_acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_sqx_ff   <= SQ_WIDTH'(p1_dx_ff) * SQ_WIDTH'(p1_dx_ff);
         p2_sqy_ff   <= SQ_WIDTH'(p1_dy_ff) * SQ_WIDTH'(p1_dy_ff);
         p2_rr_ff    <= SQ_WIDTH'(p1_reach_ff) * SQ_WIDTH'(p1_reach_ff);
         p2_same_ff  <= p1_same_ff;
         p2_start_ff <= p1_start_ff;
         p2_width_ff <= p1_width_ff;
         p2_x_ff     <= p2_x_in;
         p2_y_ff     <= p2_y_in;
         p2_acc_ff   <= p2_acc_in;
      end
   end

   assign dist_sum = SUM_W'(unsigned'(p2_sqx_ff)) + SUM_W'(unsigned'(p2_sqy_ff));
   assign far_in   = dist_sum > SUM_W'(p2_rr_ff);

   assign cordic_valid[0] = p2_valid_ff;
   assign cordic_x[0]     = p2_x_ff;
   assign cordic_y[0]     = p2_y_ff;
   assign cordic_acc[0]   = p2_acc_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      cct_cordic_stage #(
         .XY_WIDTH (XY_WIDTH),
         .STEP     (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cordic_valid[k]),
         .in_x      (cordic_x[k]),
         .in_y      (cordic_y[k]),
         .in_acc    (cordic_acc[k]),
         .out_valid (cordic_valid[k+1]),
         .out_x     (cordic_x[k+1]),
         .out_y     (cordic_y[k+1]),
         .out_acc   (cordic_acc[k+1])
      );

      if (k == 0) begin : g_side_head
         always_ff @(posedge clock) begin
            if (advance) begin
               side_same_ff[k]  <= p2_same_ff;
               side_far_ff[k]   <= far_in;
               side_start_ff[k] <= p2_start_ff;
               side_width_ff[k] <= p2_width_ff;
            end
         end
      end else begin : g_side_tail
         always_ff @(posedge clock) begin
            if (advance) begin
               side_same_ff[k]  <= side_same_ff[k-1];
               side_far_ff[k]   <= side_far_ff[k-1];
               side_start_ff[k] <= side_start_ff[k-1];
               side_width_ff[k] <= side_width_ff[k-1];
            end
         end
      end
   end

   assign acc_rounded = cordic_acc[CORDIC_STEPS] + ROUND_HALF;
   assign bearing     = acc_rounded[31 -: AW];
   assign rel         = bearing - side_start_ff[CORDIC_STEPS-1];

   always_comb begin
      if (side_same_ff[CORDIC_STEPS-1]) begin
         reason = cct_pkg::REASON_SAME_POINT;
      end else if (side_far_ff[CORDIC_STEPS-1]) begin
         reason = cct_pkg::REASON_BEYOND_REACH;
      end else if (rel < side_width_ff[CORDIC_STEPS-1]) begin
         reason = cct_pkg::REASON_CONNECTED;
      end else begin
         reason = cct_pkg::REASON_OUTSIDE_SECTOR;
      end
      rsp_data_in.connected = (reason == cct_pkg::REASON_CONNECTED);
      rsp_data_in.reason    = reason;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_same_zero_delta: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && p1_same_ff |-> p1_dx_ff == '0 && p1_dy_ff == '0)
      else $error("same-point beat carries a nonzero difference");

   a_same_zero_square: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff && p2_same_ff |-> p2_sqx_ff == '0 && p2_sqy_ff == '0)
      else $error("same-point beat carries a nonzero distance");

   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(cordic_valid[CORDIC_STEPS]) &&
                                 $stable(p2_valid_ff))
      else $error("pipeline moved while the response was stalled");

   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.connected ==
                    (rsp_data.reason == cct_pkg::REASON_CONNECTED))
      else $error("connected flag disagrees with reason code");

endmodule
